/* src/rank_select_result_cache_assert.svh */
// Assertion macros used by the checker.
`ifndef RANK_SELECT_RESULT_CACHE_ASSERT_SVH
`define RANK_SELECT_RESULT_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define RSRC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication.
`define RSRC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

/* src/rsrc_pkg.sv */
// ----------------------------------------------------------------------------
// rsrc_pkg
// Types, codes and defaults shared by the rank/select result cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsrc_pkg;

    localparam int NUM_WAYS_DEF        = 4;
    localparam int ENTRIES_PER_WAY_DEF = 16;
    localparam int AGE_WIDTH_DEF       = 32;
    localparam int KEY_W               = 48;

    // operation codes
    localparam logic [2:0] OP_RANK  = 3'd0;
    localparam logic [2:0] OP_SEL   = 3'd1;
    localparam logic [2:0] OP_HDR   = 3'd2;
    localparam logic [2:0] OP_ELEM  = 3'd3;
    localparam logic [2:0] OP_INVAL = 3'd4;

    // result status codes
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // pending fill kinds
    localparam logic [1:0] PK_IDLE = 2'd0;
    localparam logic [1:0] PK_RANK = 2'd1;
    localparam logic [1:0] PK_SEL  = 2'd2;

    typedef struct packed {
        logic [2:0]       operation;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] leaf_rank;
        logic [KEY_W-1:0] leaf_size;
        logic [KEY_W-1:0] elem_rank;
        logic [KEY_W-1:0] elem_value;
        logic             elem_last;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] answer;
        logic [1:0]       victim_way;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_BS_CHK,
        S_BS_CMP,
        S_SEL_WAIT,
        S_FIN0,
        S_FIN1,
        S_FIN2,
        S_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic scan;
        logic bs_chk;
        logic bs_cmp;
        logic sel_data;
        logic fin0;
        logic fin1;
        logic fin2;
        logic resp;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic dec_resp;
        logic dec_finish;
        logic hit_rank;
        logic hit_sel;
        logic scan_last;
        logic bs_done;
        logic out_free;
    } sts_t;

endpackage

/* src/rank_select_result_cache.sv */
// Rank hits scan the ways, then binary-search the hit way's offsets; select hits read the offset RAM;
//   a miss scans every way and reports the least recently used way as the victim.
// The last element word of a fill passes through the finish states, which read back the way's bounds from RAM.
// Throughput: one word at a time; input ready again in the cycle after the result is loaded
//   into the output register, and after the decode state for a word that gives no result.
// Reset: synchronous active-low aresetn empties all ways and clears ages and counters.
// ----------------------------------------------------------------------------
// rank_select_result_cache
// Fully associative cache of sorted set-bit offsets answering rank and select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rank_select_result_cache #(
    parameter int NUM_WAYS        = rsrc_pkg::NUM_WAYS_DEF,
    parameter int ENTRIES_PER_WAY = rsrc_pkg::ENTRIES_PER_WAY_DEF,
    parameter int AGE_WIDTH       = rsrc_pkg::AGE_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    // input words: queries, leaf header, leaf elements, invalidate
    input  logic           s_valid,
    output logic           s_ready,
    input  rsrc_pkg::in_t  s_payload,
    // result words: hit answer, fill answer or miss with victim way
    output logic           m_valid,
    input  logic           m_ready,
    output rsrc_pkg::out_t m_payload
);

    rsrc_pkg::cmd_t cmd;
    rsrc_pkg::sts_t sts;

    // Controller: sequences decode, way scan, search and refill readback.
    rsrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: way tags and ages, pending fill, offset RAM, output register.
    // The output register frees the controller to take the next word while
    // a result waits downstream.
    rsrc_datapath #(
        .NUM_WAYS        (NUM_WAYS),
        .ENTRIES_PER_WAY (ENTRIES_PER_WAY),
        .AGE_WIDTH       (AGE_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

/* src/rsrc_ram.sv */
// ----------------------------------------------------------------------------
// rsrc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsrc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/rsrc_ctrl.sv */
// ----------------------------------------------------------------------------
// rsrc_ctrl
// Sequencer: one word at a time through decode, way scan, search and refill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsrc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  rsrc_pkg::sts_t  sts,
    output rsrc_pkg::cmd_t  cmd
);

    rsrc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsrc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rsrc_pkg::S_IDLE: begin
                if (s_valid) state_next = rsrc_pkg::S_DECODE;
            end
            rsrc_pkg::S_DECODE: begin
                if (sts.is_query)        state_next = rsrc_pkg::S_SCAN;
                else if (sts.dec_finish) state_next = rsrc_pkg::S_FIN0;
                else if (sts.dec_resp)   state_next = rsrc_pkg::S_RESP;
                else                     state_next = rsrc_pkg::S_IDLE;
            end
            rsrc_pkg::S_SCAN: begin
                if (sts.hit_rank)       state_next = rsrc_pkg::S_BS_CHK;
                else if (sts.hit_sel)   state_next = rsrc_pkg::S_SEL_WAIT;
                else if (sts.scan_last) state_next = rsrc_pkg::S_RESP;
            end
            rsrc_pkg::S_BS_CHK: begin
                state_next = sts.bs_done ? rsrc_pkg::S_RESP : rsrc_pkg::S_BS_CMP;
            end
            rsrc_pkg::S_BS_CMP:   state_next = rsrc_pkg::S_BS_CHK;
            rsrc_pkg::S_SEL_WAIT: state_next = rsrc_pkg::S_RESP;
            rsrc_pkg::S_FIN0:     state_next = rsrc_pkg::S_FIN1;
            rsrc_pkg::S_FIN1:     state_next = rsrc_pkg::S_FIN2;
            rsrc_pkg::S_FIN2:     state_next = rsrc_pkg::S_RESP;
            rsrc_pkg::S_RESP: begin
                if (sts.out_free) state_next = rsrc_pkg::S_IDLE;
            end
            default: state_next = rsrc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            rsrc_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            rsrc_pkg::S_DECODE:   cmd.decode   = 1'b1;
            rsrc_pkg::S_SCAN:     cmd.scan     = 1'b1;
            rsrc_pkg::S_BS_CHK:   cmd.bs_chk   = 1'b1;
            rsrc_pkg::S_BS_CMP:   cmd.bs_cmp   = 1'b1;
            rsrc_pkg::S_SEL_WAIT: cmd.sel_data = 1'b1;
            rsrc_pkg::S_FIN0:     cmd.fin0     = 1'b1;
            rsrc_pkg::S_FIN1:     cmd.fin1     = 1'b1;
            rsrc_pkg::S_FIN2:     cmd.fin2     = 1'b1;
            rsrc_pkg::S_RESP:     cmd.resp     = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

/* src/rsrc_datapath.sv */
// ----------------------------------------------------------------------------
// rsrc_datapath
// Way registers, pending fill state, search registers, offset RAM, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsrc_datapath #(
    parameter int NUM_WAYS        = rsrc_pkg::NUM_WAYS_DEF,
    parameter int ENTRIES_PER_WAY = rsrc_pkg::ENTRIES_PER_WAY_DEF,
    parameter int AGE_WIDTH       = rsrc_pkg::AGE_WIDTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  rsrc_pkg::in_t   s_payload,
    input  rsrc_pkg::cmd_t  cmd,
    output rsrc_pkg::sts_t  sts,
    output logic            m_valid,
    input  logic            m_ready,
    output rsrc_pkg::out_t  m_payload
);

    localparam int KW    = rsrc_pkg::KEY_W;
    localparam int WW    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CW    = $clog2(ENTRIES_PER_WAY + 1);
    localparam int IW    = (ENTRIES_PER_WAY > 1) ? $clog2(ENTRIES_PER_WAY) : 1;
    localparam int DEPTH = NUM_WAYS * ENTRIES_PER_WAY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] ENT  = AW'(ENTRIES_PER_WAY);
    localparam logic [CW-1:0] ENTC = CW'(ENTRIES_PER_WAY);
    localparam logic [WW-1:0] LAST = WW'(NUM_WAYS - 1);

    // ---------------- registers ----------------
    rsrc_pkg::in_t  in_reg;
    logic [CW-1:0]        way_count_reg [NUM_WAYS];
    logic [CW-1:0]        way_count_next[NUM_WAYS];
    logic [AGE_WIDTH-1:0] way_age_reg   [NUM_WAYS];
    logic [AGE_WIDTH-1:0] way_age_next  [NUM_WAYS];
    logic [KW-1:0]        way_low_reg   [NUM_WAYS];
    logic [KW-1:0]        way_high_reg  [NUM_WAYS];
    logic [KW-1:0]        way_base_reg  [NUM_WAYS];
    logic [AGE_WIDTH-1:0] use_reg, use_next;
    logic [1:0]           pend_reg, pend_next;
    logic                 hs_reg, hs_next;
    logic [KW-1:0]        pkey_reg, pkey_next;
    logic [WW-1:0]        refill_reg, refill_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [KW-1:0]        found_reg, found_next;
    logic [KW-1:0]        lend_reg, lend_next;
    logic [WW-1:0]        idx_reg, idx_next;
    logic [AGE_WIDTH-1:0] best_reg, best_next;
    logic [WW-1:0]        oldest_reg, oldest_next;
    logic [CW-1:0]        lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [KW-1:0]        lowtmp_reg;
    logic [1:0]           rst_reg, rst_next;
    logic [KW-1:0]        rans_reg, rans_next;
    logic [WW-1:0]        rvic_reg, rvic_next;
    logic                 m_valid_reg, m_valid_next;
    rsrc_pkg::out_t       m_payload_reg;

    // ---------------- RAM ----------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [KW-1:0] ram_wdata, ram_rdata;

    rsrc_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [WW-1:0] w, input logic [IW-1:0] i);
        addr_of = AW'(w) * ENT + AW'(i);
    endfunction

    // ---------------- decode terms ----------------
    logic [2:0]    op;
    logic [KW-1:0] key, lr, ls, er, ev, lend_calc, diff_er, sel_off, pick_n;
    logic          hdr_act, hdr_resp, elem_act, elem_resp, is_rank_pend;
    logic [CW-1:0] rank_fill_new;
    logic          hit_r, hit_s, old_take;
    logic [WW-1:0] oldest_eff;
    logic [CW:0]   lohi_sum;
    logic [CW-1:0] fill_m1;

    always_comb begin
        op        = in_reg.operation;
        key       = in_reg.key;
        lr        = in_reg.leaf_rank;
        ls        = in_reg.leaf_size;
        er        = in_reg.elem_rank;
        ev        = in_reg.elem_value;
        lend_calc = lr + ls;
        diff_er   = er - pkey_reg;
        pick_n    = lend_calc - pkey_reg;
        is_rank_pend = (pend_reg == rsrc_pkg::PK_RANK);

        hdr_act  = (op == rsrc_pkg::OP_HDR) && (pend_reg != rsrc_pkg::PK_IDLE);
        hdr_resp = hdr_act && ((is_rank_pend && ls == '0) ||
                   (pend_reg == rsrc_pkg::PK_SEL &&
                    (pkey_reg < lr || pkey_reg >= lend_calc)));

        if (fill_reg != '0) begin
            rank_fill_new = (fill_reg < ENTC) ? fill_reg + CW'(1) : fill_reg;
        end else begin
            rank_fill_new = (ev >= pkey_reg) ? CW'(1) : '0;
        end
        elem_act  = (op == rsrc_pkg::OP_ELEM) && (pend_reg != rsrc_pkg::PK_IDLE) && hs_reg;
        elem_resp = elem_act && in_reg.elem_last && is_rank_pend && (rank_fill_new == '0);

        // way scan terms
        sel_off = key - way_base_reg[idx_reg];
        hit_r = (way_count_reg[idx_reg] != '0) && (way_low_reg[idx_reg] <= key) &&
                (key <= way_high_reg[idx_reg]);
        hit_s = (way_base_reg[idx_reg] <= key) && (sel_off < KW'(way_count_reg[idx_reg]));
        old_take   = (best_reg >= way_age_reg[idx_reg]);
        oldest_eff = old_take ? idx_reg : oldest_reg;

        lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        fill_m1  = fill_reg - CW'(1);

        sts.is_query   = (op == rsrc_pkg::OP_RANK) || (op == rsrc_pkg::OP_SEL);
        sts.dec_resp   = hdr_resp || elem_resp;
        sts.dec_finish = elem_act && in_reg.elem_last && !elem_resp;
        sts.hit_rank   = (op == rsrc_pkg::OP_RANK) && hit_r;
        sts.hit_sel    = (op == rsrc_pkg::OP_SEL) && hit_s;
        sts.scan_last  = (idx_reg == LAST);
        sts.bs_done    = (lo_reg == hi_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // ---------------- next state ----------------
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            way_count_next[w] = way_count_reg[w];
            way_age_next[w]   = way_age_reg[w];
        end
        use_next    = use_reg;
        pend_next   = pend_reg;
        hs_next     = hs_reg;
        pkey_next   = pkey_reg;
        refill_next = refill_reg;
        fill_next   = fill_reg;
        found_next  = found_reg;
        lend_next   = lend_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        oldest_next = oldest_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        rst_next    = rst_reg;
        rans_next   = rans_reg;
        rvic_next   = rvic_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_of(refill_reg, '0);
        ram_wdata   = ev;
        ram_raddr   = addr_of(refill_reg, '0);

        if (cmd.decode) begin
            unique case (op) inside
                rsrc_pkg::OP_RANK, rsrc_pkg::OP_SEL: begin
                    use_next = use_reg + AGE_WIDTH'(1);
                    if (use_next == '0) begin
                        for (int w = 0; w < NUM_WAYS; w++) begin
                            way_count_next[w] = '0;
                            way_age_next[w]   = '0;
                        end
                    end
                    idx_next    = '0;
                    best_next   = '1;
                    oldest_next = '0;
                end
                rsrc_pkg::OP_HDR: begin
                    if (hdr_act) begin
                        lend_next = lend_calc;
                        way_count_next[refill_reg] = '0;
                        fill_next  = '0;
                        found_next = '0;
                        hs_next    = 1'b1;
                        if (hdr_resp) begin
                            pend_next = rsrc_pkg::PK_IDLE;
                            hs_next   = 1'b0;
                            rst_next  = rsrc_pkg::ST_FILL;
                            rans_next = is_rank_pend ? lr : '0;
                            rvic_next = '0;
                        end else if (!is_rank_pend) begin
                            fill_next = (pick_n > KW'(ENTRIES_PER_WAY)) ? ENTC
                                                                        : pick_n[CW-1:0];
                        end
                    end
                end
                rsrc_pkg::OP_ELEM: begin
                    if (elem_act) begin
                        if (is_rank_pend) begin
                            fill_next = rank_fill_new;
                            if (fill_reg != '0) begin
                                ram_we    = (fill_reg < ENTC);
                                ram_waddr = addr_of(refill_reg, fill_reg[IW-1:0]);
                            end else if (ev >= pkey_reg) begin
                                found_next = er;
                                ram_we     = 1'b1;
                            end
                        end else begin
                            ram_we    = (er >= pkey_reg) && (diff_er < KW'(ENTRIES_PER_WAY));
                            ram_waddr = addr_of(refill_reg, diff_er[IW-1:0]);
                        end
                        if (elem_resp) begin
                            pend_next = rsrc_pkg::PK_IDLE;
                            hs_next   = 1'b0;
                            rst_next  = rsrc_pkg::ST_FILL;
                            rans_next = lend_reg;
                            rvic_next = '0;
                        end
                    end
                end
                rsrc_pkg::OP_INVAL: begin
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        way_count_next[w] = '0;
                        way_age_next[w]   = '0;
                    end
                    pend_next = rsrc_pkg::PK_IDLE;
                    hs_next   = 1'b0;
                end
                default: ;
            endcase
        end

        if (cmd.scan) begin
            if (sts.hit_rank) begin
                way_age_next[idx_reg] = use_reg;
                lo_next = '0;
                hi_next = way_count_reg[idx_reg];
            end else if (sts.hit_sel) begin
                way_age_next[idx_reg] = use_reg;
                ram_raddr = addr_of(idx_reg, sel_off[IW-1:0]);
            end else begin
                if (old_take) begin
                    oldest_next = idx_reg;
                    best_next   = way_age_reg[idx_reg];
                end
                if (sts.scan_last) begin
                    pend_next   = (op == rsrc_pkg::OP_RANK) ? rsrc_pkg::PK_RANK
                                                            : rsrc_pkg::PK_SEL;
                    pkey_next   = key;
                    refill_next = oldest_eff;
                    hs_next     = 1'b0;
                    fill_next   = '0;
                    rst_next    = rsrc_pkg::ST_MISS;
                    rans_next   = '0;
                    rvic_next   = oldest_eff;
                end else begin
                    idx_next = idx_reg + WW'(1);
                end
            end
        end

        if (cmd.bs_chk) begin
            mid_next  = lohi_sum[CW:1];
            ram_raddr = addr_of(idx_reg, mid_next[IW-1:0]);
            if (sts.bs_done) begin
                rst_next  = rsrc_pkg::ST_HIT;
                rans_next = way_base_reg[idx_reg] + KW'(lo_reg);
                rvic_next = '0;
            end
        end

        if (cmd.bs_cmp) begin
            if (ram_rdata < key) lo_next = mid_reg + CW'(1);
            else                 hi_next = mid_reg;
        end

        if (cmd.sel_data) begin
            rst_next  = rsrc_pkg::ST_HIT;
            rans_next = ram_rdata;
            rvic_next = '0;
        end

        if (cmd.fin1) begin
            ram_raddr = addr_of(refill_reg, fill_m1[IW-1:0]);
        end

        if (cmd.fin2) begin
            way_count_next[refill_reg] = fill_reg;
            way_age_next[refill_reg]   = use_reg;
            pend_next = rsrc_pkg::PK_IDLE;
            hs_next   = 1'b0;
            rst_next  = rsrc_pkg::ST_FILL;
            rans_next = is_rank_pend ? found_reg : lowtmp_reg;
            rvic_next = '0;
        end

        m_valid_next = m_valid_reg;
        if (cmd.resp && sts.out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                way_count_reg[w] <= '0;
                way_age_reg[w]   <= '0;
            end
            use_reg     <= '0;
            pend_reg    <= rsrc_pkg::PK_IDLE;
            hs_reg      <= 1'b0;
            refill_reg  <= '0;
            fill_reg    <= '0;
            found_reg   <= '0;
            idx_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                way_count_reg[w] <= way_count_next[w];
                way_age_reg[w]   <= way_age_next[w];
            end
            use_reg     <= use_next;
            pend_reg    <= pend_next;
            hs_reg      <= hs_next;
            refill_reg  <= refill_next;
            fill_reg    <= fill_next;
            found_reg   <= found_next;
            idx_reg     <= idx_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.accept) in_reg <= s_payload;
        pkey_reg   <= pkey_next;
        lend_reg   <= lend_next;
        best_reg   <= best_next;
        oldest_reg <= oldest_next;
        mid_reg    <= mid_next;
        rst_reg    <= rst_next;
        rans_reg   <= rans_next;
        rvic_reg   <= rvic_next;
        if (cmd.fin1) lowtmp_reg <= ram_rdata;
        if (cmd.fin2) begin
            way_low_reg[refill_reg]  <= lowtmp_reg;
            way_high_reg[refill_reg] <= ram_rdata;
            way_base_reg[refill_reg] <= is_rank_pend ? found_reg : pkey_reg;
        end
        if (cmd.resp && sts.out_free) begin
            m_payload_reg.status     <= rst_reg;
            m_payload_reg.answer     <= rans_reg;
            m_payload_reg.victim_way <= 2'(rvic_reg);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

/* src/rsrc_checker.sv */
// ----------------------------------------------------------------------------
// rsrc_checker
// Port-level checks for the rank/select result cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rank_select_result_cache_assert.svh"

module rsrc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input rsrc_pkg::out_t m_payload
);

    // a held result word keeps its contents
    `RSRC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    // one word in flight: busy right after an accept
    `RSRC_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a miss carries no answer
    `RSRC_ASSERT_IMPLY(a_miss, aclk, aresetn, m_valid && m_payload.status == rsrc_pkg::ST_MISS, m_payload.answer == '0)
    // victim way only reported on a miss
    `RSRC_ASSERT_IMPLY(a_vict, aclk, aresetn, m_valid && m_payload.status != rsrc_pkg::ST_MISS, m_payload.victim_way == '0)

endmodule

bind rank_select_result_cache rsrc_checker u_rsrc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
